/* design/particle_sensor_frame_parser_defines.svh */
// Assertion macros for the particulate sensor frame parser.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PSFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psfp assertion failed");

// Next-cycle implication, checked out of reset.
`define PSFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psfp assertion failed");

`endif

/* design/psfp_pkg.sv */
// Shared types and constants of the particulate sensor frame parser.
// No dependencies.
`default_nettype none

package psfp_pkg;

    localparam int MAX_FRAME_DEF = 32;
    localparam int MIN_FRAME     = 2;
    localparam int FLEN_W        = 6;
    localparam int OFF_W         = 5;

    localparam logic [7:0]        START_BYTE_RST      = 8'h42;
    localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST    = 6'd32;
    localparam logic [FLEN_W-1:0] SUM_COUNT_RST       = 6'd30;
    localparam logic [OFF_W-1:0]  CHECKSUM_OFFSET_RST = 5'd30;
    localparam logic [OFF_W-1:0]  PM1_OFFSET_RST      = 5'd10;
    localparam logic [OFF_W-1:0]  PM25_OFFSET_RST     = 5'd12;
    localparam logic [OFF_W-1:0]  PM10_OFFSET_RST     = 5'd14;
    localparam logic [15:0]       ERR_VALUE           = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_START_BYTE      = 3'd0,
        REG_FRAME_LENGTH    = 3'd1,
        REG_SUM_COUNT       = 3'd2,
        REG_CHECKSUM_OFFSET = 3'd3,
        REG_PM1_OFFSET      = 3'd4,
        REG_PM25_OFFSET     = 3'd5,
        REG_PM10_OFFSET     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_word_t;

    typedef struct packed {
        logic [15:0] pm1_value;
        logic [15:0] pm25_value;
        logic [15:0] pm10_value;
        logic        checksum_ok;
    } result_word_t;

    typedef struct packed {
        logic [2:0] index;
        logic [7:0] wdata;
    } cfg_word_t;

endpackage

`default_nettype wire

/* design/psfp_stream_if.sv */
// Valid/ready channel carrying one word of a packed payload type.
// No dependencies; the payload type is set at instantiation.
`default_nettype none

interface psfp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/particle_sensor_frame_parser.sv */
// Particulate sensor UART frame parser, top level.
// Uses psfp_pkg, psfp_stream_if and particle_sensor_frame_parser_defines.svh.
//
// Channels: rx takes one received byte per word; result gives one word per
// completed frame (PM1, PM2.5, PM10, checksum_ok; readings all ones on a
// checksum mismatch); cfg writes one register per word (index, wdata) and
// is always ready. Writes take effect on the next byte.
// Throughput: one byte per cycle while rx.ready is high. The frame state
// (sum, captures, index) is updated in the cycle a frame byte is accepted;
// the result word goes to the output register, or to skid while it is held.
// A two-entry output (result register plus skid register) lets rx keep
// flowing while a result waits; rx.ready drops only when both are full.
// Reset: registers return to their defaults (start 0x42, length 32, sum
// count 30, checksum at 30, readings at 10/12/14), the parser hunts for a
// start byte and no result is pending.
`default_nettype none
`include "particle_sensor_frame_parser_defines.svh"

module particle_sensor_frame_parser
    import psfp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psfp_stream_if.sink   rx,
    psfp_stream_if.source result,
    psfp_stream_if.sink   cfg
);

    localparam int IDX_W = $clog2(MAX_FRAME);
    localparam int CMP_W = (((IDX_W + 1) > FLEN_W) ? (IDX_W + 1) : FLEN_W) + 1;

    logic [7:0]        start_byte_reg;
    logic [FLEN_W-1:0] frame_length_reg;
    logic [FLEN_W-1:0] sum_count_reg;
    logic [OFF_W-1:0]  checksum_offset_reg;
    logic [OFF_W-1:0]  pm1_offset_reg;
    logic [OFF_W-1:0]  pm25_offset_reg;
    logic [OFF_W-1:0]  pm10_offset_reg;

    logic              in_frame_reg, in_frame_next;
    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic [15:0]       running_sum_reg, running_sum_next;
    logic [15:0]       expected_sum_reg, expected_sum_next;
    logic [15:0]       pm1_cap_reg, pm1_cap_next;
    logic [15:0]       pm25_cap_reg, pm25_cap_next;
    logic [15:0]       pm10_cap_reg, pm10_cap_next;

    result_word_t      out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    result_word_t      skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              rx_acc;
    logic              start_hit;
    logic              take;
    logic              done;
    logic              emit;
    logic              out_free;
    logic [7:0]        b;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  next_pos;
    logic [CMP_W-1:0]  len_raw;
    logic [CMP_W-1:0]  len_eff;
    logic [15:0]       sum_base;
    logic [15:0]       sum_new;
    logic [15:0]       exp_new;
    logic [15:0]       pm1_new;
    logic [15:0]       pm25_new;
    logic [15:0]       pm10_new;
    logic              sum_ok;
    result_word_t      res_word;

    function automatic logic [15:0] put_byte(
        input logic [15:0]      word,
        input logic [OFF_W-1:0] off,
        input logic [CMP_W-1:0] p,
        input logic [7:0]       val
    );
        logic [CMP_W-1:0] hi_pos;
        logic [CMP_W-1:0] lo_pos;
        hi_pos = CMP_W'(off);
        lo_pos = hi_pos + CMP_W'(1);
        if (p == hi_pos)
        begin
            return {val, word[7:0]};
        end
        else if (p == lo_pos)
        begin
            return {word[15:8], val};
        end
        return word;
    endfunction

    // Configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg      <= START_BYTE_RST;
            frame_length_reg    <= FRAME_LENGTH_RST;
            sum_count_reg       <= SUM_COUNT_RST;
            checksum_offset_reg <= CHECKSUM_OFFSET_RST;
            pm1_offset_reg      <= PM1_OFFSET_RST;
            pm25_offset_reg     <= PM25_OFFSET_RST;
            pm10_offset_reg     <= PM10_OFFSET_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_START_BYTE:      start_byte_reg      <= cfg.data.wdata;
                REG_FRAME_LENGTH:    frame_length_reg    <= cfg.data.wdata[FLEN_W-1:0];
                REG_SUM_COUNT:       sum_count_reg       <= cfg.data.wdata[FLEN_W-1:0];
                REG_CHECKSUM_OFFSET: checksum_offset_reg <= cfg.data.wdata[OFF_W-1:0];
                REG_PM1_OFFSET:      pm1_offset_reg      <= cfg.data.wdata[OFF_W-1:0];
                REG_PM25_OFFSET:     pm25_offset_reg     <= cfg.data.wdata[OFF_W-1:0];
                REG_PM10_OFFSET:     pm10_offset_reg     <= cfg.data.wdata[OFF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Frame datapath
    assign rx.ready  = !skid_valid_reg;
    assign rx_acc    = rx.valid && rx.ready;
    assign b         = rx.data.rx_byte;
    assign start_hit = !in_frame_reg && (b == start_byte_reg);
    assign take      = rx_acc && (in_frame_reg || start_hit);

    assign pos      = in_frame_reg ? CMP_W'(byte_index_reg) : '0;
    assign next_pos = pos + CMP_W'(1);
    assign len_raw  = CMP_W'(frame_length_reg);

    always_comb
    begin
        if (len_raw < CMP_W'(MIN_FRAME))
        begin
            len_eff = CMP_W'(MIN_FRAME);
        end
        else if (len_raw > CMP_W'(MAX_FRAME))
        begin
            len_eff = CMP_W'(MAX_FRAME);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    // a new frame starts from cleared sum and captures
    assign sum_base = in_frame_reg ? running_sum_reg : '0;
    assign sum_new  = (pos < CMP_W'(sum_count_reg)) ? (sum_base + {8'd0, b}) : sum_base;
    assign exp_new  = put_byte(in_frame_reg ? expected_sum_reg : '0,
                               checksum_offset_reg, pos, b);
    assign pm1_new  = put_byte(in_frame_reg ? pm1_cap_reg : '0, pm1_offset_reg, pos, b);
    assign pm25_new = put_byte(in_frame_reg ? pm25_cap_reg : '0, pm25_offset_reg, pos, b);
    assign pm10_new = put_byte(in_frame_reg ? pm10_cap_reg : '0, pm10_offset_reg, pos, b);

    assign done   = in_frame_reg && (next_pos >= len_eff);
    assign emit   = rx_acc && done;
    assign sum_ok = (sum_new == exp_new);

    always_comb
    begin
        res_word.pm1_value   = sum_ok ? pm1_new  : ERR_VALUE;
        res_word.pm25_value  = sum_ok ? pm25_new : ERR_VALUE;
        res_word.pm10_value  = sum_ok ? pm10_new : ERR_VALUE;
        res_word.checksum_ok = sum_ok;
    end

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        byte_index_next   = byte_index_reg;
        running_sum_next  = running_sum_reg;
        expected_sum_next = expected_sum_reg;
        pm1_cap_next      = pm1_cap_reg;
        pm25_cap_next     = pm25_cap_reg;
        pm10_cap_next     = pm10_cap_reg;
        if (take)
        begin
            in_frame_next     = !done;
            byte_index_next   = done ? '0 : next_pos[IDX_W-1:0];
            running_sum_next  = sum_new;
            expected_sum_next = exp_new;
            pm1_cap_next      = pm1_new;
            pm25_cap_next     = pm25_new;
            pm10_cap_next     = pm10_new;
        end
    end

    // Output register plus skid entry
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = emit;
                if (emit)
                begin
                    out_next = res_word;
                end
            end
        end
        else if (emit)
        begin
            skid_next       = res_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            byte_index_reg   <= '0;
            running_sum_reg  <= '0;
            expected_sum_reg <= '0;
            pm1_cap_reg      <= '0;
            pm25_cap_reg     <= '0;
            pm10_cap_reg     <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            byte_index_reg   <= byte_index_next;
            running_sum_reg  <= running_sum_next;
            expected_sum_reg <= expected_sum_next;
            pm1_cap_reg      <= pm1_cap_next;
            pm25_cap_reg     <= pm25_cap_next;
            pm10_cap_reg     <= pm10_cap_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Checks
    `PSFP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `PSFP_ASSERT_NOW(a_hunt_index_zero, !in_frame_reg, byte_index_reg == '0)
    `PSFP_ASSERT_NEXT(a_done_gives_result, emit, out_valid_reg)
    `PSFP_ASSERT_NOW(a_bad_sum_all_ones, out_valid_reg && !out_reg.checksum_ok,
        (out_reg.pm1_value == ERR_VALUE) && (out_reg.pm25_value == ERR_VALUE)
        && (out_reg.pm10_value == ERR_VALUE))

endmodule

`default_nettype wire
